@@ design/lssp_pkg.sv @@
// Shared widths, type codes and helper functions for the linear scale and pack unit.
`timescale 1ns / 1ps
`default_nettype none

package lssp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 64;
    localparam int DIFF_W    = VAL_W + 1;
    localparam int PROD_W    = 130;
    localparam int NUM_W     = PROD_W + 1;
    localparam int QB        = VAL_W + FRAC_BITS + 2;
    localparam int RW        = DIFF_W;
    localparam int YW        = QB + 2;
    localparam int MI_W      = QB - FRAC_BITS;

    localparam logic [3:0] CT_BOOL = 4'd0;
    localparam logic [3:0] CT_U8   = 4'd1;
    localparam logic [3:0] CT_S8   = 4'd2;
    localparam logic [3:0] CT_U16  = 4'd3;
    localparam logic [3:0] CT_S16  = 4'd4;
    localparam logic [3:0] CT_U32  = 4'd5;
    localparam logic [3:0] CT_S32  = 4'd6;
    localparam logic [3:0] CT_U64  = 4'd7;
    localparam logic [3:0] CT_S64  = 4'd8;

    typedef struct packed {
        logic              vld;
        logic [VAL_W-1:0]  cl;
        logic [VAL_W-1:0]  ch;
        logic              limit;
        logic [3:0]        ctype;
        logic              last;
        logic              err;
    } t_side;

    typedef struct packed {
        logic [RW-1:0]     rem;
        logic [QB-1:0]     nq;
        logic [DIFF_W-1:0] den;
        logic              neg;
        logic              ovf;
    } t_div;

    function automatic logic [3:0] f_type_bytes(input logic [3:0] ctype);
        logic [3:0] nb;
        case (ctype)
            CT_BOOL, CT_U8, CT_S8: nb = 4'd1;
            CT_U16, CT_S16:        nb = 4'd2;
            CT_U32, CT_S32:        nb = 4'd4;
            CT_U64, CT_S64:        nb = 4'd8;
            default:               nb = 4'd0;
        endcase
        return nb;
    endfunction

    function automatic logic f_type_signed(input logic [3:0] ctype);
        logic s;
        case (ctype)
            CT_S8, CT_S16, CT_S32, CT_S64: s = 1'b1;
            default:                       s = 1'b0;
        endcase
        return s;
    endfunction

    function automatic logic [VAL_W-1:0] f_type_hi(input logic [3:0] ctype);
        logic [VAL_W-1:0] hi;
        case (ctype)
            CT_BOOL, CT_U8: hi = 64'h0000_0000_0000_00FF;
            CT_S8:          hi = 64'h0000_0000_0000_007F;
            CT_U16:         hi = 64'h0000_0000_0000_FFFF;
            CT_S16:         hi = 64'h0000_0000_0000_7FFF;
            CT_U32:         hi = 64'h0000_0000_FFFF_FFFF;
            CT_S32:         hi = 64'h0000_0000_7FFF_FFFF;
            CT_U64:         hi = 64'hFFFF_FFFF_FFFF_FFFF;
            CT_S64:         hi = 64'h7FFF_FFFF_FFFF_FFFF;
            default:        hi = '0;
        endcase
        return hi;
    endfunction

endpackage

`default_nettype wire

@@ design/lssp_mul.sv @@
// Three-stage signed 65 by 64 bit multiplier built from four 33 by 33 bit partial products.
`timescale 1ns / 1ps
`default_nettype none

module lssp_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic signed [lssp_pkg::DIFF_W-1:0] i_a,
    input  wire logic signed [lssp_pkg::VAL_W-1:0]  i_b,
    output logic signed [lssp_pkg::PROD_W-1:0]      o_p
);
    import lssp_pkg::*;

    logic signed [32:0] ah, al, bh, bl;
    logic signed [65:0] r_ll, r_lh, r_hl, r_hh;
    logic signed [66:0] r_mid;
    logic        [63:0] r_ll2;
    logic signed [65:0] r_hh2;
    logic signed [PROD_W-1:0] r_p;

    assign ah = i_a[64:32];
    assign al = {1'b0, i_a[31:0]};
    assign bh = {i_b[63], i_b[63:32]};
    assign bl = {1'b0, i_b[31:0]};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll  <= al * bl;
            r_lh  <= al * bh;
            r_hl  <= ah * bl;
            r_hh  <= ah * bh;
            r_mid <= {r_lh[65], r_lh} + {r_hl[65], r_hl};
            r_ll2 <= r_ll[63:0];
            r_hh2 <= r_hh;
            // The high and low products do not overlap, so they are simply joined.
            r_p   <= $signed({r_hh2, r_ll2}) + $signed({{31{r_mid[66]}}, r_mid, 32'b0});
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

@@ design/lssp_div_cell.sv @@
// One restoring division cell: produces one quotient bit and hands its state on.
`timescale 1ns / 1ps
`default_nettype none

module lssp_div_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire lssp_pkg::t_div  i_div,
    input  wire lssp_pkg::t_side i_side,
    output lssp_pkg::t_div       o_div,
    output lssp_pkg::t_side      o_side
);
    import lssp_pkg::*;

    logic [RW:0]   trial;
    logic [RW:0]   diff;
    logic          ge;
    t_div          n_div;
    t_div          r_div;
    t_side         r_side;

    always_comb begin
        trial = {i_div.rem, i_div.nq[QB-1]};
        diff  = trial - {1'b0, i_div.den};
        ge    = trial >= {1'b0, i_div.den};
        n_div     = i_div;
        n_div.rem = ge ? diff[RW-1:0] : trial[RW-1:0];
        n_div.nq  = {i_div.nq[QB-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= '0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

`default_nettype wire

@@ design/lssp_pack.sv @@
// Byte serializer: loads one saturated integer and sends its bytes least significant first.
`timescale 1ns / 1ps
`default_nettype none

module lssp_pack (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire lssp_pkg::t_side            i_side,
    input  wire logic [lssp_pkg::VAL_W-1:0] i_mag,
    input  wire logic                       i_neg,
    output logic                            o_take,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // [7:0] data_byte
    output logic                            m_axis_tlast,   // entry_end
    output logic [1:0]                      m_axis_tuser    // [0] message_end, [1] range_error
);
    import lssp_pkg::*;

    logic             r_busy;
    logic [VAL_W-1:0] r_val;
    logic [2:0]       r_idx;
    logic [2:0]       r_nb_m1;
    logic             r_last;
    logic             r_err;
    logic [3:0]       nb;
    logic [3:0]       nb_m1;
    logic             at_end;

    assign nb     = f_type_bytes(i_side.ctype);
    assign nb_m1  = nb - 4'd1;
    assign at_end = r_idx == r_nb_m1;
    assign o_take = !r_busy || (m_axis_tready && at_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_take) begin
            // An entry of an undefined type produces no transfer at all.
            r_busy <= i_side.vld && (nb != 4'd0);
            r_idx  <= '0;
        end else if (m_axis_tready) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_val   <= i_neg ? (~i_mag + 64'd1) : i_mag;
            r_nb_m1 <= nb_m1[2:0];
            r_last  <= i_side.last;
            r_err   <= i_side.err;
        end
    end

    assign m_axis_tvalid = r_busy;
    assign m_axis_tdata  = r_val[{r_idx, 3'b000} +: 8];
    assign m_axis_tlast  = at_end;
    assign m_axis_tuser  = {r_err, r_last && at_end};

endmodule

`default_nettype wire

@@ design/linear_scale_saturate_pack_unit.sv @@
// Top level: linear range scaling, clipping, rounding, saturation and little-endian packing.
//
//  Channel  | Direction | tdata                                   | tuser / tlast
//  s_axis   | in        | host_value, host_low, host_high,        | [0] limit_enable,
//           |           | client_low, client_high (64 bits each)  | [4:1] client_type; tlast last_entry
//  m_axis   | out       | data_byte                               | [0] message_end,
//           |           |                                         | [1] range_error; tlast entry_end
//
// An entry enters whenever s_axis_tready is high; the divider chain of one cell per quotient bit forms
// most of the pipeline. Bytes leave at one per cycle while m_axis_tready is high, so an entry of a type
// with n bytes occupies the output for n transfers.
// When the last pipeline stage holds an entry that the byte serializer cannot take, every stage
// holds and s_axis_tready drops. The synchronous reset clears all valid flags; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module linear_scale_saturate_pack_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [63:0] host_value, [127:64] host_low, [191:128] host_high,
    // [255:192] client_low, [319:256] client_high
    input  wire logic [319:0] s_axis_tdata,
    input  wire logic [4:0]   s_axis_tuser,   // [0] limit_enable, [4:1] client_type
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] data_byte
    output logic [1:0]        m_axis_tuser,   // [0] message_end, [1] range_error
    output logic              m_axis_tlast
);
    import lssp_pkg::*;

    logic en;
    logic take;

    // Input register
    t_side            r_s0_side;
    logic [VAL_W-1:0] r_s0_v, r_s0_hl, r_s0_hh;

    // Differences
    t_side                    r_s1_side;
    t_side                    n_s1_side;
    logic signed [DIFF_W-1:0] r_s1_dch, r_s1_den, r_s1_clx, r_s1_chx;
    logic signed [VAL_W-1:0]  r_s1_v, r_s1_hl, r_s1_hh;
    logic [DIFF_W-1:0]        n_den;

    // Alignment with the multipliers
    t_side             r_md_side [3];
    logic [DIFF_W-1:0] r_md_den  [3];
    logic signed [PROD_W-1:0] p1, p2, p3;

    t_side                   r_s5_side;
    logic [DIFF_W-1:0]       r_s5_den;
    logic signed [NUM_W-1:0] r_s5_sub, r_s5_p1;

    t_side             r_s6_side;
    logic [DIFF_W-1:0] r_s6_den;
    logic [NUM_W-1:0]  r_s6_num;
    logic [NUM_W-1:0]  n_sum;

    t_side             r_s7_side;
    logic [NUM_W-1:0]  r_s7_nmag;
    logic [DIFF_W-1:0] r_s7_dmag;
    logic              r_s7_neg;

    t_side r_s8_side;
    t_div  r_s8_div;
    t_div  n_s8_div;

    t_div  chain_div  [QB+1];
    t_side chain_side [QB+1];

    t_side         r_r0_side;
    logic [YW-1:0] r_r0_y;
    logic [YW-1:0] n_mag;

    t_side         r_r1_side;
    logic [YW-1:0] r_r1_y;
    logic [YW-1:0] n_clip, lo2, hi2;

    t_side           r_r2_side;
    logic [MI_W-1:0] r_r2_mi;
    logic            r_r2_neg;
    logic [YW-1:0]   n_rnd;
    logic            yneg;

    t_side            r_r3_side;
    logic [VAL_W-1:0] r_r3_mag;
    logic             r_r3_neg;
    logic [VAL_W-1:0] n_sat;
    logic             n_sneg;
    logic [MI_W-1:0]  hi_w, hip1_w;

    assign en            = !r_r3_side.vld || take;
    assign s_axis_tready = en;

    always_comb begin
        n_s1_side     = r_s0_side;
        n_s1_side.err = n_den == '0;
    end

    // Control flags: only the valid bits need a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_side <= '0;
            r_s1_side <= '0;
            r_md_side <= '{default: '0};
            r_s5_side <= '0;
            r_s6_side <= '0;
            r_s7_side <= '0;
            r_s8_side <= '0;
            r_r0_side <= '0;
            r_r1_side <= '0;
            r_r2_side <= '0;
            r_r3_side <= '0;
        end else if (en) begin
            r_s0_side.vld   <= s_axis_tvalid;
            r_s0_side.cl    <= s_axis_tdata[255:192];
            r_s0_side.ch    <= s_axis_tdata[319:256];
            r_s0_side.limit <= s_axis_tuser[0];
            r_s0_side.ctype <= s_axis_tuser[4:1];
            r_s0_side.last  <= s_axis_tlast;
            r_s0_side.err   <= 1'b0;
            r_s1_side       <= n_s1_side;
            r_md_side[0]    <= r_s1_side;
            r_md_side[1]    <= r_md_side[0];
            r_md_side[2]    <= r_md_side[1];
            r_s5_side       <= r_md_side[2];
            r_s6_side       <= r_s5_side;
            r_s7_side       <= r_s6_side;
            r_s8_side       <= r_s7_side;
            r_r0_side       <= chain_side[QB];
            r_r1_side       <= r_r0_side;
            r_r2_side       <= r_r1_side;
            r_r3_side       <= r_r2_side;
        end
    end

    assign n_den = {r_s0_hh[VAL_W-1], r_s0_hh} - {r_s0_hl[VAL_W-1], r_s0_hl};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_v   <= s_axis_tdata[63:0];
            r_s0_hl  <= s_axis_tdata[127:64];
            r_s0_hh  <= s_axis_tdata[191:128];
            r_s1_dch <= {r_s0_side.ch[VAL_W-1], r_s0_side.ch}
                      - {r_s0_side.cl[VAL_W-1], r_s0_side.cl};
            r_s1_den <= n_den;
            r_s1_clx <= {r_s0_side.cl[VAL_W-1], r_s0_side.cl};
            r_s1_chx <= {r_s0_side.ch[VAL_W-1], r_s0_side.ch};
            r_s1_v   <= r_s0_v;
            r_s1_hl  <= r_s0_hl;
            r_s1_hh  <= r_s0_hh;
            r_md_den[0] <= r_s1_den;
            r_md_den[1] <= r_md_den[0];
            r_md_den[2] <= r_md_den[1];
            r_s5_den <= r_md_den[2];
            r_s5_sub <= {p2[PROD_W-1], p2} - {p3[PROD_W-1], p3};
            r_s5_p1  <= {p1[PROD_W-1], p1};
            r_s6_den <= r_s5_den;
            // The numerator is doubled to keep one extra fraction bit for rounding.
            r_s6_num <= {n_sum[NUM_W-2:0], 1'b0};
            r_s7_neg  <= r_s6_num[NUM_W-1] ^ r_s6_den[DIFF_W-1];
            r_s7_nmag <= r_s6_num[NUM_W-1] ? (~r_s6_num + 1'b1) : r_s6_num;
            r_s7_dmag <= r_s6_den[DIFF_W-1] ? (~r_s6_den + 1'b1) : r_s6_den;
            r_s8_div  <= n_s8_div;
            r_r0_y    <= chain_div[QB].neg ? (~n_mag + 1'b1) : n_mag;
            r_r1_y    <= n_clip;
            r_r2_neg  <= yneg;
            r_r2_mi   <= n_rnd[FRAC_BITS+1 +: MI_W];
            r_r3_mag  <= n_sat;
            r_r3_neg  <= n_sneg;
        end
    end

    assign n_sum = r_s5_p1 + r_s5_sub;

    lssp_mul u_mul_slope (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s1_dch),
        .i_b   (r_s1_v),
        .o_p   (p1)
    );

    lssp_mul u_mul_low (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s1_clx),
        .i_b   (r_s1_hh),
        .o_p   (p2)
    );

    lssp_mul u_mul_high (
        .i_clk (i_clk),
        .i_en  (en),
        .i_a   (r_s1_chx),
        .i_b   (r_s1_hl),
        .o_p   (p3)
    );

    // A quotient too large for QB bits is beyond every clip bound and every type range,
    // so only the overflow itself is kept.
    always_comb begin
        n_s8_div.rem = RW'(r_s7_nmag[NUM_W-1:QB]);
        n_s8_div.nq  = r_s7_nmag[QB-1:0];
        n_s8_div.den = r_s7_dmag;
        n_s8_div.neg = r_s7_neg;
        n_s8_div.ovf = RW'(r_s7_nmag[NUM_W-1:QB]) >= r_s7_dmag;
    end

    assign chain_div[0]  = r_s8_div;
    assign chain_side[0] = r_s8_side;

    for (genvar gi = 0; gi < QB; gi++) begin : g_div
        lssp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_div   (chain_div[gi]),
            .i_side  (chain_side[gi]),
            .o_div   (chain_div[gi+1]),
            .o_side  (chain_side[gi+1])
        );
    end

    assign n_mag = chain_div[QB].ovf ? {2'b01, {QB{1'b0}}} : {2'b00, chain_div[QB].nq};

    always_comb begin
        lo2    = {{(YW-DIFF_W){r_r0_side.cl[VAL_W-1]}}, r_r0_side.cl, 1'b0};
        hi2    = {{(YW-DIFF_W){r_r0_side.ch[VAL_W-1]}}, r_r0_side.ch, 1'b0};
        n_clip = r_r0_y;
        if (r_r0_side.limit) begin
            if ($signed(n_clip) > $signed(hi2)) begin
                n_clip = hi2;
            end
            if ($signed(n_clip) < $signed(lo2)) begin
                n_clip = lo2;
            end
        end
    end

    // Magnitude plus one half, then drop the fraction bits: rounds half away from zero.
    assign yneg  = r_r1_y[YW-1];
    assign n_rnd = (yneg ? ~r_r1_y : r_r1_y) + YW'(2 ** FRAC_BITS) + YW'(yneg);

    always_comb begin
        hi_w   = MI_W'(f_type_hi(r_r2_side.ctype));
        hip1_w = hi_w + 1'b1;
        n_sat  = r_r2_mi[VAL_W-1:0];
        n_sneg = r_r2_neg;
        if (r_r2_side.err) begin
            n_sat  = '0;
            n_sneg = 1'b0;
        end else if (!r_r2_neg) begin
            if (r_r2_mi > hi_w) begin
                n_sat = hi_w[VAL_W-1:0];
            end
        end else if (!f_type_signed(r_r2_side.ctype)) begin
            n_sat  = '0;
            n_sneg = 1'b0;
        end else if (r_r2_mi > hip1_w) begin
            n_sat = hip1_w[VAL_W-1:0];
        end
    end

    lssp_pack u_pack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_side        (r_r3_side),
        .i_mag         (r_r3_mag),
        .i_neg         (r_r3_neg),
        .o_take        (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking bench for the linear scale, saturate and pack unit.
`timescale 1ns / 1ps

module testbench;
    import lssp_pkg::*;

    localparam int LATENCY   = 120;
    localparam int MAX_CYCLE = 1500000;

    typedef struct {
        logic signed [63:0] value;
        logic signed [63:0] h_lo;
        logic signed [63:0] h_hi;
        logic signed [63:0] c_lo;
        logic signed [63:0] c_hi;
        logic               clip;
        logic [3:0]         ctype;
        logic               last;
    } entry_t;

    typedef struct {
        logic [7:0] data;
        logic       entry_end;
        logic       msg_end;
        logic       err;
    } byte_t;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata;
    logic [4:0]   s_axis_tuser;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    entry_t pending_entries[$];
    byte_t  expected_bytes[$];
    int     error_count;
    int     cycle_count;
    int     send_gap;
    int     recv_gap;
    int     hold_off;
    bit     stim_done;
    bit     drain_req;
    bit     hold_req;

    linear_scale_saturate_pack_unit uut (.*);

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Exact scaling in wide two's complement, then clip, round and saturate.
    task automatic predict_bytes(input entry_t e);
        logic signed [255:0] den, num, y2, mag, lo, hi;
        logic [255:0]        q;
        logic [63:0]         packed_val;
        int                  nbytes;
        logic                sgn, err, end_b;
        byte_t               b;
        nbytes = f_type_bytes(e.ctype);
        sgn    = f_type_signed(e.ctype);
        den    = 256'(e.h_hi) - 256'(e.h_lo);
        err    = (den == 0);
        packed_val = '0;
        if (!err) begin
            num = (256'(e.c_hi) - 256'(e.c_lo)) * 256'(e.value)
                + 256'(e.c_lo) * 256'(e.h_hi) - 256'(e.c_hi) * 256'(e.h_lo);
            num = num * 2;
            q = (num < 0 ? -num : num) / (den < 0 ? -den : den);
            y2 = ((num < 0) != (den < 0)) ? -$signed(q) : $signed(q);
            if (e.clip) begin
                if (y2 > 256'(e.c_hi) * 2) y2 = 256'(e.c_hi) * 2;
                if (y2 < 256'(e.c_lo) * 2) y2 = 256'(e.c_lo) * 2;
            end
            mag = ((y2 < 0 ? -y2 : y2) + (256'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1);
            y2  = (y2 < 0) ? -mag : mag;
            if (sgn) begin
                hi = $signed({192'd0, f_type_hi(e.ctype)});
                lo = -hi - 1;
            end else begin
                hi = $signed({192'd0, f_type_hi(e.ctype)});
                lo = 0;
            end
            if (y2 > hi) y2 = hi;
            if (y2 < lo) y2 = lo;
            packed_val = y2[63:0];
        end
        for (int j = 0; j < nbytes; j++) begin
            end_b = (j == nbytes - 1);
            b = '{packed_val[8*j +: 8], end_b, end_b && e.last, err};
            expected_bytes = {expected_bytes, b};
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_fixed(input int ibits);
        logic signed [63:0] v;
        v = $signed(rand64()) >>> (63 - ibits - FRAC_BITS);
        return v;
    endfunction

    task automatic add_entry(input logic [63:0] v, hl, hh, cl, ch,
                             input logic clip, input logic [3:0] ct, input logic last);
        entry_t e;
        e = '{v, hl, hh, cl, ch, clip, ct, last};
        pending_entries = {pending_entries, e};
    endtask

    // Driver: offers queued entries with random gaps, pausing on request until drained.
    always @(posedge i_clk) begin
        entry_t e;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap      <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_bytes(pending_entries.pop_front());
            end
            if ((s_axis_tvalid && !s_axis_tready) ) begin
                // Hold the current transfer.
            end else if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (pending_entries.size() > 0 && !(drain_req && expected_bytes.size() > 0)
                         && !(s_axis_tvalid && s_axis_tready && pending_entries.size() == 0)) begin
                e = pending_entries[0];
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {e.c_hi, e.c_lo, e.h_hi, e.h_lo, e.value};
                s_axis_tuser  <= {e.ctype, e.clip};
                s_axis_tlast  <= e.last;
                send_gap      <= rand_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, including one long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_gap      <= 0;
            hold_off      <= 0;
        end else if (hold_req && hold_off == 0) begin
            hold_off      <= 400;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 1) begin
            hold_off      <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap      <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            recv_gap      <= rand_gap();
        end
    end

    // Monitor: compares every output transfer with the oldest expected byte.
    always @(posedge i_clk) begin
        byte_t x;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte %h", $time, m_axis_tdata);
                error_count++;
            end else begin
                x = expected_bytes.pop_front();
                if (x.data !== m_axis_tdata || x.entry_end !== m_axis_tlast
                    || x.msg_end !== m_axis_tuser[0] || x.err !== m_axis_tuser[1]) begin
                    $display("%0t: expected byte %h end %b msg %b err %b, got %h end %b msg %b err %b",
                             $time, x.data, x.entry_end, x.msg_end, x.err,
                             m_axis_tdata, m_axis_tlast, m_axis_tuser[0], m_axis_tuser[1]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [63:0] hl, hh;
        logic [3:0]  ct;
        error_count   = 0;
        cycle_count   = 0;
        stim_done     = 0;
        drain_req     = 0;
        hold_req      = 0;
        i_rst_n       = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        s_axis_tlast  = 1'b0;
        // Directed: every type, extremes, empty host range, reversed client bounds.
        for (int t = 0; t <= 8; t++) begin
            add_entry(64'sd5 <<< FRAC_BITS, 0, 64'sd10 <<< FRAC_BITS,
                      -(64'sd100 <<< FRAC_BITS), 64'sd100 <<< FRAC_BITS, t[0], t[3:0], t == 8);
        end
        add_entry(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, CT_S64, 1'b0);
        add_entry(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1, CT_U64, 1'b1);
        add_entry(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                  64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b0, CT_U64, 1'b0);
        add_entry(64'sd3 <<< FRAC_BITS, 64'sd7, 64'sd7, 0, 64'sd1, 1'b0, CT_S32, 1'b1);
        add_entry(64'sd3 <<< FRAC_BITS, 64'sd7, 64'sd7, 0, 64'sd1, 1'b1, CT_S8, 1'b0);
        add_entry(64'sd50 <<< FRAC_BITS, 0, 64'sd100 <<< FRAC_BITS,
                  64'sd10 <<< FRAC_BITS, -(64'sd10 <<< FRAC_BITS), 1'b1, CT_S16, 1'b0);
        // Exact half values round away from zero.
        add_entry(64'sd1, 0, 64'sd2, 0, 64'sd1 <<< FRAC_BITS, 1'b0, CT_S8, 1'b0);
        add_entry(-64'sd1, 0, 64'sd2, 0, 64'sd1 <<< FRAC_BITS, 1'b0, CT_S8, 1'b0);
        add_entry(64'sd1, 0, 64'sd1, 0, 64'sd1000 <<< FRAC_BITS, 1'b0, CT_S16, 1'b0);
        add_entry(64'sd1, 0, 64'sd1, 0, 64'sd1000 <<< FRAC_BITS, 1'b0, 4'd9, 1'b1);
        add_entry(rand64(), rand64(), rand64(), rand64(), rand64(), 1'b1, 4'd15, 1'b0);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_entries.size() == 0 && !s_axis_tvalid);
        for (int i = 0; i < 500; i++) begin
            int kind;
            kind = $urandom_range(0, 99);
            ct   = (kind < 95) ? 4'($urandom_range(0, 8)) : 4'($urandom_range(9, 15));
            if (kind < 5) begin
                hl = rand64();
                add_entry(rand64(), hl, hl, rand64(), rand64(), 1'($urandom), ct, 1'($urandom));
            end else if (kind < 20) begin
                add_entry(rand64(), rand64(), rand64(), rand64(), rand64(), 1'($urandom), ct,
                          1'($urandom));
            end else begin
                hl = rand_fixed($urandom_range(2, 40));
                hh = rand_fixed($urandom_range(2, 40));
                add_entry(rand_fixed($urandom_range(2, 40)), hl, hh,
                          rand_fixed($urandom_range(2, 40)), rand_fixed($urandom_range(2, 40)),
                          1'($urandom), ct, ($urandom_range(0, 3) == 0));
            end
            // The receiver runs its long hold-off once, while many entries are still queued.
            if (i == 150) begin
                hold_req = 1;
            end
            if (i == 300) begin
                wait (pending_entries.size() == 0 && !s_axis_tvalid);
                drain_req = 1;
            end
            if (i == 320) begin
                wait (pending_entries.size() == 0 && !s_axis_tvalid);
                drain_req = 0;
            end
        end
        wait (pending_entries.size() == 0 && !s_axis_tvalid);
        wait (expected_bytes.size() == 0);
        repeat (LATENCY) @(posedge i_clk);
        if (error_count == 0 && expected_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        s_axis_tvalid = 1'b0;
        m_axis_tready = 1'b0;
    end

endmodule
